@@ hw/rtl/sit_pkg.sv @@
// ----------------------------------------------------------------------------
// String intern table package
// Shared sizes, status codes and the escape translation function.
// ----------------------------------------------------------------------------
package sit_pkg;

   localparam int PoolBytes  = 1024;
   localparam int MaxEntries = 256;
   localparam int MaxLen     = 64;

   localparam int PoolAw  = $clog2(PoolBytes);
   localparam int EntryAw = $clog2(MaxEntries);
   localparam int LenAw   = $clog2(MaxLen);

   localparam logic [10:0] PoolReset = 11'(PoolBytes < 2047 ? PoolBytes : 2047);

   typedef enum logic [1:0] {
      OP_LOOKUP = 2'd0,
      OP_ADD    = 2'd1,
      OP_ADDESC = 2'd2,
      OP_CLEAR  = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_FOUND    = 3'd0,
      ST_ADDED    = 3'd1,
      ST_NOTFOUND = 3'd2,
      ST_OVERFLOW = 3'd3,
      ST_LONG     = 3'd4
   } status_type;

   typedef struct packed {
      logic [7:0] entry_index;
      logic [2:0] status;
      logic       cleared;
   } rsp_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] char_byte;
      logic       last_byte;
   } req_type;

   function automatic logic [7:0] esc_map(input logic [7:0] c);
      case (c)
         8'h61:   esc_map = 8'h07;
         8'h62:   esc_map = 8'h08;
         8'h66:   esc_map = 8'h0c;
         8'h6e:   esc_map = 8'h0a;
         8'h72:   esc_map = 8'h0d;
         8'h74:   esc_map = 8'h09;
         8'h76:   esc_map = 8'h0b;
         default: esc_map = c;
      endcase
   endfunction

endpackage

@@ hw/rtl/sit_if.sv @@
// ----------------------------------------------------------------------------
// String intern table channel interfaces
// Valid/ready channels for requests and responses.
// ----------------------------------------------------------------------------
interface sit_req_if import sit_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] char_byte;
   logic       last_byte;
   modport source (output valid, opcode, char_byte, last_byte, input ready);
   modport sink (input valid, opcode, char_byte, last_byte, output ready);
endinterface

interface sit_rsp_if import sit_pkg::*; ();
   logic       valid;
   logic       ready;
   logic [7:0] entry_index;
   logic [2:0] status;
   logic       cleared;
   modport source (output valid, entry_index, status, cleared, input ready);
   modport sink (input valid, entry_index, status, cleared, output ready);
endinterface

@@ hw/rtl/sit_ram.sv @@
// ----------------------------------------------------------------------------
// Generic single-port-write, single-port-read RAM
// Registered read data, no reset of contents.
// ----------------------------------------------------------------------------
module sit_ram #(
   parameter int Width = 8,
   parameter int Depth = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(Depth)-1:0] waddr,
   input  logic [Width-1:0]         wdata,
   input  logic [$clog2(Depth)-1:0] raddr,
   output logic [Width-1:0]         rdata
);
   logic [Width-1:0] mem [Depth];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule

@@ hw/rtl/string_intern_table.sv @@
// ----------------------------------------------------------------------------
// String intern table
// Byte strings are buffered, then searched and optionally stored in a pool.
// ----------------------------------------------------------------------------
//  channel | direction | payload
//  req     | in        | opcode, char_byte, last_byte
//  rsp     | out       | entry_index, status, cleared
//  csr     | in        | pool_bytes (write only)
// A non-final byte is only buffered. A final byte starts a walk over the
// stored entries: each entry's offset is read (S_OFF, S_OFFW), then its
// bytes are compared (S_CMP, S_CMPW); for an add the bytes are then written
// back (S_WR), and S_RSP registers the response. A clear or a too-long string answers directly.
// Reset is synchronous; the memories hold no reset value and need no sweep.
// A pending response holds off the input; no byte is taken until it is delivered.
module string_intern_table import sit_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   sit_req_if.sink     req,
   sit_rsp_if.source   rsp,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);
   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_OFF  = 7'b0000010,
      S_OFFW = 7'b0000100,
      S_CMP  = 7'b0001000,
      S_CMPW = 7'b0010000,
      S_WR   = 7'b0100000,
      S_RSP  = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic [10:0] pool_ff, pool_in;
   logic [10:0] free_ff, free_in;
   logic [EntryAw:0] cnt_ff, cnt_in;
   logic [LenAw:0] plen_ff, plen_in;   // saturates at MaxLen+1
   logic [1:0] pop_ff, pop_in;
   logic [EntryAw:0] ent_ff, ent_in;
   logic [LenAw:0] k_ff, k_in;
   logic [10:0] off_ff, off_in;
   logic [10:0] w_ff, w_in;
   logic esc_ff, esc_in;
   rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;

   // pending string buffer
   logic [7:0] pend_mem [MaxLen];
   logic [7:0] pend_rd;
   logic [LenAw-1:0] pend_ra;

   // pool and offset memories
   logic pw_we;
   logic [PoolAw-1:0] pw_a, pr_a;
   logic [7:0] pw_d, pr_d;
   logic ow_we;
   logic [EntryAw-1:0] ow_a, or_a;
   logic [10:0] or_d;

   sit_ram #(.Width(8), .Depth(PoolBytes)) u_pool (
      .clock(clock), .we(pw_we), .waddr(pw_a), .wdata(pw_d),
      .raddr(pr_a), .rdata(pr_d));
   sit_ram #(.Width(11), .Depth(MaxEntries)) u_offs (
      .clock(clock), .we(ow_we), .waddr(ow_a), .wdata(off_ff),
      .raddr(or_a), .rdata(or_d));

   wire acc = req.valid && req.ready;
   wire [1:0] eop = (plen_ff == '0) ? req.opcode : pop_ff;

   always_ff @(posedge clock) begin
      if (acc && plen_ff < (LenAw+1)'(MaxLen)) pend_mem[plen_ff[LenAw-1:0]] <= req.char_byte;
      pend_rd <= pend_mem[pend_ra];
   end

   wire [11:0] addr_k = 12'(off_ff) + 12'(k_ff);
   wire        pool_in_range = addr_k < 12'(PoolBytes);
   wire [7:0]  sb = pool_in_range ? pr_d : 8'd0;
   wire [10:0] poollim = (pool_ff < 11'(PoolBytes)) ? pool_ff : 11'(PoolBytes);
   wire [12:0] need = 13'(plen_ff) + 13'd1 + ((13'(cnt_ff) + 13'd1) << 1);
   wire [10:0] newoff = free_ff - 11'(plen_ff) - 11'd1;

   assign req.ready = (state_ff == S_IDLE) && !rv_ff;
   assign rsp.valid = rv_ff;
   assign rsp.entry_index = rsp_ff.entry_index;
   assign rsp.status = rsp_ff.status;
   assign rsp.cleared = rsp_ff.cleared;

   always_comb begin
      state_in = state_ff; pool_in = csr_we ? csr_wdata : pool_ff;
      free_in = free_ff; cnt_in = cnt_ff; plen_in = plen_ff; pop_in = pop_ff;
      ent_in = ent_ff; k_in = k_ff; off_in = off_ff; w_in = w_ff; esc_in = esc_ff;
      rsp_in = rsp_ff; rv_in = rv_ff && !rsp.ready;
      pend_ra = k_ff[LenAw-1:0]; pr_a = addr_k[PoolAw-1:0];
      or_a = ent_ff[EntryAw-1:0];
      pw_we = 1'b0; pw_a = w_ff[PoolAw-1:0]; pw_d = 8'd0;
      ow_we = 1'b0; ow_a = cnt_ff[EntryAw-1:0];
      case (state_ff)
         S_IDLE: begin
            if (acc) begin
               pop_in = eop;
               if (plen_ff <= (LenAw+1)'(MaxLen)) plen_in = plen_ff + 1'b1;
               if (req.last_byte) begin
                  ent_in = '0;
                  if (eop == OP_CLEAR) begin
                     cnt_in = '0; free_in = poollim; plen_in = '0;
                     rsp_in = '{8'd0, ST_LONG, 1'b1}; rv_in = 1'b1;
                  end else if (plen_ff >= (LenAw+1)'(MaxLen)) begin
                     plen_in = '0;
                     rsp_in = '{8'd0, ST_LONG, 1'b0}; rv_in = 1'b1;
                  end else state_in = S_OFF;
               end
            end
         end
         S_OFF: begin
            // ent_ff selects the entry; its offset arrives next cycle
            if (ent_ff >= cnt_ff) begin
               if (pop_ff == OP_LOOKUP) begin
                  rsp_in = '{8'd0, ST_NOTFOUND, 1'b0}; state_in = S_RSP;
               end else if (cnt_ff >= (EntryAw+1)'(MaxEntries) || 13'(free_ff) < need) begin
                  rsp_in = '{8'd0, ST_OVERFLOW, 1'b0}; state_in = S_RSP;
               end else begin
                  off_in = newoff; w_in = newoff; k_in = '0; esc_in = 1'b0;
                  state_in = S_WR;
               end
            end else state_in = S_OFFW;
         end
         S_OFFW: begin
            off_in = or_d; k_in = '0; state_in = S_CMP;
         end
         S_CMP: state_in = S_CMPW;   // pool and pending reads in flight
         S_CMPW: begin
            if (k_ff == plen_ff) begin
               if (sb == 8'd0) begin
                  rsp_in = '{ent_ff[7:0], ST_FOUND, 1'b0}; state_in = S_RSP;
               end else begin
                  ent_in = ent_ff + 1'b1; state_in = S_OFF;
               end
            end else if (sb == 8'd0 || sb != pend_rd) begin
               ent_in = ent_ff + 1'b1; state_in = S_OFF;
            end else begin
               k_in = k_ff + 1'b1; state_in = S_CMP;
            end
         end
         S_WR: begin
            // pend_rd holds byte k_ff-1 from the previous cycle; k_ff=0 primes.
            if (k_ff != '0) begin
               if (k_ff == plen_ff + 1'b1) begin
                  pw_we = w_ff < 11'(PoolBytes); pw_d = 8'd0;
                  ow_we = 1'b1;
                  rsp_in = '{cnt_ff[7:0], ST_ADDED, 1'b0};
                  cnt_in = cnt_ff + 1'b1; free_in = off_ff; state_in = S_RSP;
               end else if (pop_ff == OP_ADD || esc_ff) begin
                  pw_we = w_ff < 11'(PoolBytes);
                  pw_d = esc_ff ? esc_map(pend_rd) : pend_rd;
                  w_in = w_ff + 1'b1; esc_in = 1'b0;
               end else if (pend_rd == 8'h5c) esc_in = 1'b1;
               else begin
                  pw_we = w_ff < 11'(PoolBytes); pw_d = pend_rd; w_in = w_ff + 1'b1;
               end
            end
            if (k_ff != plen_ff + 1'b1) k_in = k_ff + 1'b1;
         end
         S_RSP: begin
            rv_in = 1'b1; plen_in = '0; state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE; pool_ff <= PoolReset;
         free_ff <= (PoolReset < 11'(PoolBytes)) ? PoolReset : 11'(PoolBytes);
         cnt_ff <= '0; plen_ff <= '0; pop_ff <= '0; rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in; pool_ff <= pool_in; free_ff <= free_in;
         cnt_ff <= cnt_in; plen_ff <= plen_in; pop_ff <= pop_in; rv_ff <= rv_in;
      end
      ent_ff <= ent_in; k_ff <= k_in; off_ff <= off_in; w_ff <= w_in;
      esc_ff <= esc_in; rsp_ff <= rsp_in;
   end
endmodule

@@ test/tb_string_intern_table.sv @@
// ----------------------------------------------------------------------------
// String intern table testbench
// Sends byte strings for lookup, add, escaped add and clear, and predicts
// every response from a behavioral copy of the table. Both channels idle at
// random. The pool size register is changed only while idle, after a drain.
// ----------------------------------------------------------------------------
module tb_string_intern_table;
   import sit_pkg::*;

   typedef struct {
      logic [7:0] entry_index;
      status_type status;
      logic       cleared;
   } answer_type;

   localparam int CycleLimit = 3000000;

   logic        clock;
   logic        reset;
   logic        csr_we;
   logic [10:0] csr_wdata;

   sit_req_if req ();
   sit_rsp_if rsp ();

   string_intern_table dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req),
      .rsp       (rsp),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Behavioral copy of the table.
   logic [7:0]  pool_mem [PoolBytes];
   int unsigned entry_off [MaxEntries];
   int unsigned entry_cnt;
   int unsigned free_pos;
   int unsigned pool_size;
   logic [7:0]  pend_str [MaxLen];
   int unsigned pend_len;
   logic [1:0]  pend_op;

   answer_type  answer_q [$];
   int          errors;
   int          cycles;
   int          bytes_sent;
   int          status_seen [5];
   int          hold_cycles;
   logic [7:0]  words [24][$];

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("FAIL string_intern_table");
         $finish;
      end
   end

   task automatic report(input string what);
      errors++;
      $display("mismatch at cycle %0d: %s", cycles, what);
   endtask

   function automatic logic [7:0] pool_read(input int unsigned a);
      return a < PoolBytes ? pool_mem[a] : 8'h00;
   endfunction

   function automatic void pool_write(input int unsigned a, input logic [7:0] v);
      if (a < PoolBytes) pool_mem[a] = v;
   endfunction

   function automatic logic [7:0] unescape(input logic [7:0] c);
      case (c)
         "a":     return 8'h07;
         "b":     return 8'h08;
         "f":     return 8'h0c;
         "n":     return 8'h0a;
         "r":     return 8'h0d;
         "t":     return 8'h09;
         "v":     return 8'h0b;
         default: return c;
      endcase
   endfunction

   function automatic bit find_string(input int unsigned len, output int unsigned idx);
      logic [7:0] sb;
      bit         hit;
      for (int unsigned i = 0; i < entry_cnt && i < MaxEntries; i++) begin
         hit = 1'b1;
         for (int unsigned k = 0; k <= len; k++) begin
            sb = pool_read(entry_off[i] + k);
            if (k == len) begin
               hit = (sb == 8'h00);
               break;
            end
            if (sb == 8'h00 || k >= MaxLen || sb != pend_str[k]) begin
               hit = 1'b0;
               break;
            end
         end
         if (hit) begin
            idx = i;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   // Updates the table copy for one accepted byte and queues any answer.
   function automatic void intern_byte(input logic [1:0] op, input logic [7:0] b,
                                       input logic last);
      answer_type  ans;
      int unsigned len, idx, need, off, w;
      bit          esc;
      if (pend_len == 0) pend_op = op;
      if (pend_len < MaxLen) pend_str[pend_len] = b;
      if (pend_len <= MaxLen) pend_len++;
      if (!last) return;
      len = pend_len;
      pend_len = 0;
      ans.entry_index = 8'h00;
      ans.cleared = 1'b0;
      if (pend_op == OP_CLEAR) begin
         entry_cnt = 0;
         free_pos = pool_size < PoolBytes ? pool_size : PoolBytes;
         ans.status = ST_LONG;
         ans.cleared = 1'b1;
      end else if (len > MaxLen) begin
         ans.status = ST_LONG;
      end else if (find_string(len, idx)) begin
         ans.status = ST_FOUND;
         ans.entry_index = idx[7:0];
      end else if (pend_op == OP_LOOKUP) begin
         ans.status = ST_NOTFOUND;
      end else begin
         need = (len + 1) + (entry_cnt + 1) * 2;
         if (entry_cnt >= MaxEntries || free_pos < need) begin
            ans.status = ST_OVERFLOW;
         end else begin
            off = free_pos - (len + 1);
            w = off;
            esc = 1'b0;
            for (int unsigned k = 0; k < len; k++) begin
               if (pend_op == OP_ADD) begin
                  pool_write(w++, pend_str[k]);
               end else if (esc) begin
                  pool_write(w++, unescape(pend_str[k]));
                  esc = 1'b0;
               end else if (pend_str[k] == "\\") begin
                  esc = 1'b1;
               end else begin
                  pool_write(w++, pend_str[k]);
               end
            end
            pool_write(w, 8'h00);
            ans.entry_index = entry_cnt[7:0];
            entry_off[entry_cnt] = off;
            entry_cnt++;
            free_pos = off;
            ans.status = ST_ADDED;
         end
      end
      answer_q.push_back(ans);
   endfunction

   // Response side: random stall per transaction, or a long hold when asked.
   initial begin
      int         stall;
      answer_type exp_ans;
      rsp.ready = 1'b0;
      @(negedge reset);
      forever begin
         if (hold_cycles > 0) begin
            stall = hold_cycles;
            hold_cycles = 0;
         end else begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 6);
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         @(posedge clock);
         while (!rsp.valid) @(posedge clock);
         if (answer_q.size() == 0) begin
            report($sformatf("unexpected response idx=%0d status=%0d",
                             rsp.entry_index, rsp.status));
         end else begin
            exp_ans = answer_q.pop_front();
            if (rsp.status < 5) status_seen[rsp.status]++;
            if (rsp.entry_index !== exp_ans.entry_index)
               report($sformatf("entry_index %0d, expected %0d",
                                rsp.entry_index, exp_ans.entry_index));
            if (rsp.status !== exp_ans.status)
               report($sformatf("status %0d, expected %0d", rsp.status, exp_ans.status));
            if (rsp.cleared !== exp_ans.cleared)
               report($sformatf("cleared %0b, expected %0b", rsp.cleared, exp_ans.cleared));
         end
      end
   end

   task automatic send_byte(input logic [1:0] op, input logic [7:0] b, input logic last);
      int gap;
      gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid     <= 1'b1;
      req.opcode    <= op;
      req.char_byte <= b;
      req.last_byte <= last;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      intern_byte(op, b, last);
      bytes_sent++;
   endtask

   // Later bytes of a string may carry a different opcode when scrambled.
   task automatic send_string(input opcode_type op, input logic [7:0] s[$],
                              input bit scramble = 1'b0);
      logic [1:0] cur;
      for (int i = 0; i < s.size(); i++) begin
         cur = (i > 0 && scramble) ? 2'($urandom_range(0, 3)) : op;
         send_byte(cur, s[i], i == s.size() - 1);
      end
   endtask

   task automatic send_clear(input int n);
      for (int i = 0; i < n; i++)
         send_byte(OP_CLEAR, 8'($urandom_range(1, 255)), i == n - 1);
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      while (answer_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_pool_size(input logic [10:0] v);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we    <= 1'b0;
      pool_size = v;
   endtask

   function automatic void make_string(ref logic [7:0] s[$], input int len);
      logic [7:0] alpha [8];
      alpha = '{"a", "b", "n", "t", "q", "\\", 8'h01, 8'hff};
      s.delete();
      for (int i = 0; i < len; i++)
         s.push_back($urandom_range(0, 2) == 0 ? 8'($urandom_range(1, 255))
                                              : alpha[$urandom_range(0, 7)]);
   endfunction

   task automatic test_directed();
      send_string(OP_ADD, '{"a", "b", "c"});
      send_string(OP_LOOKUP, '{"a", "b", "c"});
      send_string(OP_LOOKUP, '{"a", "b", "d"});
      send_string(OP_ADD, '{"a", "b", "c"});
      send_string(OP_ADDESC, '{"a", "\\", "n"});
      send_string(OP_LOOKUP, '{"a", 8'h0a});
      send_string(OP_ADDESC, '{"\\", "q"});
      send_string(OP_ADDESC, '{"x", "\\"});
      send_string(OP_LOOKUP, '{"x"});
      send_string(OP_ADD, '{8'h01, 8'hff});
      send_string(OP_LOOKUP, '{8'hff}, 1'b1);
      send_clear(2);
      send_string(OP_LOOKUP, '{"a", "b", "c"});
   endtask

   // Strings at and past the length limit, and a long clear.
   task automatic test_length_limit();
      logic [7:0] s[$];
      make_string(s, MaxLen);
      send_string(OP_ADD, s);
      send_string(OP_LOOKUP, s);
      make_string(s, MaxLen + 1);
      send_string(OP_ADD, s);
      send_clear(MaxLen + 2);
   endtask

   task automatic test_pool_size();
      logic [10:0] sizes [4];
      logic [7:0]  s[$];
      sizes = '{11'd64, 11'd2047, 11'd300, 11'd1024};
      foreach (sizes[p]) begin
         write_pool_size(sizes[p]);
         send_clear(1);
         for (int i = 0; i < 4; i++) begin
            make_string(s, $urandom_range(4, 12));
            send_string(i % 2 ? OP_ADDESC : OP_ADD, s);
         end
      end
   endtask

   // The response side holds off while strings keep coming, so the input stalls.
   task automatic test_backpressure();
      logic [7:0] s[$];
      drain();
      hold_cycles = 400;
      for (int i = 0; i < 8; i++) begin
         make_string(s, $urandom_range(1, 4));
         send_string(OP_LOOKUP, s);
      end
      drain();
   endtask

   task automatic test_random(input int target);
      logic [7:0] s[$];
      int         pick;
      opcode_type op;
      foreach (words[w]) make_string(words[w], $urandom_range(1, 6));
      while (bytes_sent < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            write_pool_size(11'($urandom_range(64, 1024)));
            send_clear($urandom_range(1, 3));
         end else if (pick < 5) begin
            send_clear($urandom_range(1, 3));
         end else if (pick < 8) begin
            drain();
         end else begin
            pick = $urandom_range(0, 99);
            op = pick < 40 ? OP_LOOKUP : pick < 70 ? OP_ADD : OP_ADDESC;
            pick = $urandom_range(0, 99);
            if (pick < 80) s = words[$urandom_range(0, 23)];
            else if (pick < 97) make_string(s, $urandom_range(1, 10));
            else make_string(s, $urandom_range(MaxLen - 2, MaxLen + 4));
            send_string(op, s, $urandom_range(0, 9) == 0);
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      csr_we = 1'b0;
      csr_wdata = '0;
      req.valid = 1'b0;
      req.opcode = '0;
      req.char_byte = '0;
      req.last_byte = 1'b0;
      errors = 0;
      cycles = 0;
      bytes_sent = 0;
      hold_cycles = 0;
      entry_cnt = 0;
      pend_len = 0;
      pend_op = '0;
      pool_size = PoolReset;
      free_pos = PoolReset < PoolBytes ? PoolReset : PoolBytes;
      foreach (pool_mem[i]) pool_mem[i] = 8'h00;
      foreach (status_seen[i]) status_seen[i] = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_length_limit();
      test_pool_size();
      test_backpressure();
      test_random(540);
      drain();
      repeat (200) @(posedge clock);

      $display("covered %0d bytes: %0d found, %0d added, %0d not found, %0d overflow,",
               bytes_sent, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      $display("  %0d too long or clear acks, pool sizes 64 to 2047", status_seen[4]);
      if (errors == 0) begin
         $display("PASS string_intern_table");
      end else begin
         $display("FAIL string_intern_table");
      end
      $finish;
   end

endmodule
